@@ hdl/tga_image_stream_decoder_defines.svh @@
// Assertion macros shared by the TGA stream decoder RTL.
`ifndef TGA_IMAGE_STREAM_DECODER_DEFINES_SVH
`define TGA_IMAGE_STREAM_DECODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TGAD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("TGA decoder check failed in the same cycle.");

// Checks that the consequent holds in the cycle after the antecedent.
`define TGAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("TGA decoder check failed in the following cycle.");

`endif

@@ hdl/tgad_pkg.sv @@
// Types and constants shared by the TGA stream decoder modules.
`timescale 1ns / 1ps

package tgad_pkg;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic [2:0] CHAN_RGB  = 3'd3;
   localparam logic [2:0] CHAN_RGBA = 3'd4;

   localparam logic [7:0] RLE_IMAGE_TYPE = 8'd10;
   localparam logic [4:0] HEADER_DEPTH_POS = 5'd16;
   localparam logic [7:0] RUN_FLAG_LIMIT = 8'd128;
   localparam logic [7:0] RUN_COUNT_BIAS = 8'd127;
   localparam logic [7:0] DEPTH_16 = 8'd16;
   localparam logic [7:0] DEPTH_24 = 8'd24;
   localparam logic [7:0] DEPTH_32 = 8'd32;
   localparam logic [4:0] CHANNEL_MASK = 5'h1f;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic [7:0]  repeat_res;
      logic [2:0]  channel_count;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        last;
   } rsp_payload_type;

endpackage

@@ hdl/tgad_channels.sv @@
// Handshake interfaces for the byte input channel and the result channel.
`timescale 1ns / 1ps

interface tgad_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       start_of_file;

   modport source (output valid, output data_byte, output start_of_file, input ready);
   modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tgad_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [7:0]  alpha;
   logic [7:0]  repeat_res;
   logic [2:0]  channel_count;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic        last;

   modport source (output valid, output kind, output red, output green, output blue,
                   output alpha, output repeat_res, output channel_count,
                   output image_width, output image_height, output last,
                   input ready);
   modport sink (input valid, input kind, input red, input green, input blue,
                 input alpha, input repeat_res, input channel_count,
                 input image_width, input image_height, input last,
                 output ready);
endinterface

@@ hdl/tgad_core.sv @@
// Header parser and pixel decoder state with its combinational update logic.
`timescale 1ns / 1ps

module tgad_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   input  logic                      start_of_file,
   output logic                      has_result,
   output tgad_pkg::rsp_payload_type result
);
   import tgad_pkg::*;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SKIP   = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   logic [1:0]  phase_ff, phase_in, phase_cur;
   logic [4:0]  hpos_ff, hpos_in, hpos_cur;
   logic [7:0]  id_len_ff, id_len_in, id_len_cur;
   logic        rle_ff, rle_in, rle_cur;
   logic [15:0] width_ff, width_in, width_cur;
   logic [15:0] height_ff, height_in, height_cur;
   logic [5:0]  depth_ff, depth_in, depth_cur;
   logic [8:0]  skip_ff, skip_in, skip_cur;
   logic [31:0] pix_ff, pix_in, pix_cur;
   logic [7:0]  pkt_ff, pkt_in, pkt_cur;
   logic        pkt_run_ff, pkt_run_in, pkt_run_cur;
   logic [23:0] color_ff, color_in, color_cur;
   logic [1:0]  bip_ff, bip_in, bip_cur;

   logic        depth_ok;
   logic [2:0]  bpp;
   logic [23:0] color_base;
   logic [15:0] packed_555;
   logic [7:0]  rep_raw;
   logic [7:0]  rep_clip;
   logic [31:0] pix_left;
   logic [7:0]  pix_red, pix_green, pix_blue, pix_alpha;
   logic [2:0]  chan;

   always_comb begin
      if (start_of_file) begin
         phase_cur   = PH_HEADER;
         hpos_cur    = '0;
         id_len_cur  = '0;
         rle_cur     = 1'b0;
         width_cur   = '0;
         height_cur  = '0;
         depth_cur   = '0;
         skip_cur    = '0;
         pix_cur     = '0;
         pkt_cur     = '0;
         pkt_run_cur = 1'b0;
         color_cur   = '0;
         bip_cur     = '0;
      end else begin
         phase_cur   = phase_ff;
         hpos_cur    = hpos_ff;
         id_len_cur  = id_len_ff;
         rle_cur     = rle_ff;
         width_cur   = width_ff;
         height_cur  = height_ff;
         depth_cur   = depth_ff;
         skip_cur    = skip_ff;
         pix_cur     = pix_ff;
         pkt_cur     = pkt_ff;
         pkt_run_cur = pkt_run_ff;
         color_cur   = color_ff;
         bip_cur     = bip_ff;
      end
   end

   always_comb begin
      phase_in   = phase_cur;
      hpos_in    = hpos_cur;
      id_len_in  = id_len_cur;
      rle_in     = rle_cur;
      width_in   = width_cur;
      height_in  = height_cur;
      depth_in   = depth_cur;
      skip_in    = skip_cur;
      pix_in     = pix_cur;
      pkt_in     = pkt_cur;
      pkt_run_in = pkt_run_cur;
      color_in   = color_cur;
      bip_in     = bip_cur;

      depth_ok   = 1'b0;
      bpp        = depth_cur[5:3];
      color_base = '0;
      packed_555 = '0;
      rep_raw    = 8'd1;
      rep_clip   = 8'd1;
      pix_left   = pix_cur;
      pix_red    = '0;
      pix_green  = '0;
      pix_blue   = '0;
      pix_alpha  = '0;
      chan       = (depth_cur == DEPTH_32[5:0]) ? CHAN_RGBA : CHAN_RGB;
      has_result = 1'b0;
      result     = '0;

      case (phase_cur)
         PH_HEADER: begin
            case (hpos_cur)
               5'd0:  id_len_in = data_byte;
               5'd2:  rle_in = (data_byte == RLE_IMAGE_TYPE);
               5'd12: width_in = {width_cur[15:8], data_byte};
               5'd13: width_in = {data_byte, width_cur[7:0]};
               5'd14: height_in = {height_cur[15:8], data_byte};
               5'd15: height_in = {data_byte, height_cur[7:0]};
               default: ;
            endcase
            if (hpos_cur < HEADER_DEPTH_POS) begin
               hpos_in = hpos_cur + 5'd1;
            end else begin
               hpos_in  = '0;
               depth_in = data_byte[5:0];
               if (rle_cur) begin
                  depth_ok = (data_byte == DEPTH_24) || (data_byte == DEPTH_32);
               end else begin
                  depth_ok = (data_byte == DEPTH_16) || (data_byte == DEPTH_24) ||
                             (data_byte == DEPTH_32);
               end
               has_result          = 1'b1;
               result.image_width  = width_in;
               result.image_height = height_in;
               if (!depth_ok) begin
                  phase_in    = PH_DONE;
                  result.kind = KIND_ERROR;
               end else begin
                  skip_in    = {1'b0, id_len_cur} + 9'd1;
                  pix_in     = {16'd0, width_cur} * {16'd0, height_cur};
                  pkt_in     = '0;
                  pkt_run_in = 1'b0;
                  color_in   = '0;
                  bip_in     = '0;
                  phase_in   = PH_SKIP;
                  result.kind          = KIND_HEADER;
                  result.channel_count = (data_byte == DEPTH_32) ? CHAN_RGBA : CHAN_RGB;
               end
            end
         end
         PH_SKIP: begin
            if (skip_cur != '0) begin
               skip_in = skip_cur - 9'd1;
            end
            if (skip_in == '0) begin
               phase_in = (pix_cur != '0) ? PH_PIXELS : PH_DONE;
            end
         end
         PH_PIXELS: begin
            if (rle_cur && (pkt_cur == '0)) begin
               if (data_byte < RUN_FLAG_LIMIT) begin
                  pkt_run_in = 1'b0;
                  pkt_in     = data_byte + 8'd1;
               end else begin
                  pkt_run_in = 1'b1;
                  pkt_in     = data_byte - RUN_COUNT_BIAS;
               end
               bip_in = '0;
            end else begin
               color_base = (bip_cur == 2'd0) ? 24'd0 : color_cur;
               if (bip_cur != 2'd3) begin
                  color_in = color_base | ({16'd0, data_byte} << {bip_cur, 3'b000});
               end else begin
                  color_in = color_base;
               end
               if (({1'b0, bip_cur} + 3'd1) < bpp) begin
                  bip_in = bip_cur + 2'd1;
               end else begin
                  bip_in = '0;
                  if (bpp == 3'd2) begin
                     packed_555 = {data_byte, color_in[7:0]};
                     pix_blue   = {packed_555[4:0] & CHANNEL_MASK, 3'b000};
                     pix_green  = {packed_555[9:5] & CHANNEL_MASK, 3'b000};
                     pix_red    = {packed_555[14:10] & CHANNEL_MASK, 3'b000};
                  end else begin
                     pix_blue  = color_in[7:0];
                     pix_green = color_in[15:8];
                     pix_red   = color_in[23:16];
                     if (bpp == 3'd4) begin
                        pix_alpha = data_byte;
                     end
                  end
                  if (rle_cur) begin
                     if (pkt_run_cur) begin
                        rep_raw = pkt_cur;
                        pkt_in  = '0;
                     end else begin
                        pkt_in = pkt_cur - 8'd1;
                     end
                  end
                  if ({24'd0, rep_raw} > pix_cur) begin
                     rep_clip = pix_cur[7:0];
                  end else begin
                     rep_clip = rep_raw;
                  end
                  pix_left = pix_cur - {24'd0, rep_clip};
                  pix_in   = pix_left;
                  if (pix_left == '0) begin
                     phase_in = PH_DONE;
                  end
                  has_result           = 1'b1;
                  result.kind          = KIND_PIXEL;
                  result.red           = pix_red;
                  result.green         = pix_green;
                  result.blue          = pix_blue;
                  result.alpha         = pix_alpha;
                  result.repeat_res    = rep_clip;
                  result.channel_count = chan;
                  result.image_width   = width_cur;
                  result.image_height  = height_cur;
                  result.last          = (pix_left == '0);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hpos_ff    <= '0;
         id_len_ff  <= '0;
         rle_ff     <= 1'b0;
         width_ff   <= '0;
         height_ff  <= '0;
         depth_ff   <= '0;
         skip_ff    <= '0;
         pix_ff     <= '0;
         pkt_ff     <= '0;
         pkt_run_ff <= 1'b0;
         color_ff   <= '0;
         bip_ff     <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         hpos_ff    <= hpos_in;
         id_len_ff  <= id_len_in;
         rle_ff     <= rle_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         depth_ff   <= depth_in;
         skip_ff    <= skip_in;
         pix_ff     <= pix_in;
         pkt_ff     <= pkt_in;
         pkt_run_ff <= pkt_run_in;
         color_ff   <= color_in;
         bip_ff     <= bip_in;
      end
   end

endmodule

@@ hdl/tgad_out_reg.sv @@
// Result register that drives the result channel and decides when the pipeline advances.
`timescale 1ns / 1ps

module tgad_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  logic                      has_result,
   input  tgad_pkg::rsp_payload_type result,
   output logic                      advance,
   tgad_rsp_if.source                rsp_ch
);
   import tgad_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;
   logic            load;

   assign advance  = !valid_ff || rsp_ch.ready;
   assign load     = advance && item_valid && has_result;
   assign valid_in = advance ? load : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.kind          = data_ff.kind;
   assign rsp_ch.red           = data_ff.red;
   assign rsp_ch.green         = data_ff.green;
   assign rsp_ch.blue          = data_ff.blue;
   assign rsp_ch.alpha         = data_ff.alpha;
   assign rsp_ch.repeat_res    = data_ff.repeat_res;
   assign rsp_ch.channel_count = data_ff.channel_count;
   assign rsp_ch.image_width   = data_ff.image_width;
   assign rsp_ch.image_height  = data_ff.image_height;
   assign rsp_ch.last          = data_ff.last;

endmodule

@@ hdl/tga_image_stream_decoder.sv @@
// Top level of the TGA byte stream decoder.
// The decoder takes a TGA file one byte per transfer on req_ch and returns
// header, pixel and error results on rsp_ch. A byte marked start_of_file
// restarts header parsing before it is used. On the depth byte of the header
// one header result (or one error result for an unsupported depth) is sent,
// the descriptor byte and the ID field are skipped, and the pixel bytes then
// give one pixel result per pixel, or per run for run-length packets, with a
// repeat count.
// Each byte passes an input register and then the decoder state update,
// which loads the result register, so a result appears on rsp_ch once the
// byte that completes it has left the input register, and it can be
// transferred at the next rising edge. One byte is taken every cycle while
// no held result stalls the input; the core's state update sets that rate.
// Bytes that complete no result leave nothing on rsp_ch.
// Reset is synchronous and returns the decoder to header parsing with no
// result pending. When the receiver holds rsp_ch.ready low, the result stays
// on the channel, one more byte can wait in the input register, and req_ch
// then stalls until the result is transferred.
`timescale 1ns / 1ps
`include "tga_image_stream_decoder_defines.svh"

module tga_image_stream_decoder (
   input logic        clock,
   input logic        reset,
   tgad_req_if.sink   req_ch,
   tgad_rsp_if.source rsp_ch
);
   import tgad_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   logic [7:0]      s1_byte_ff;
   logic            s1_sof_ff;
   logic            advance;
   logic            accept;
   logic            step;
   logic            has_result;
   rsp_payload_type result;

   assign req_ch.ready = !s1_valid_ff || advance;
   assign accept       = req_ch.valid && req_ch.ready;
   assign step         = s1_valid_ff && advance;
   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_ch.data_byte;
         s1_sof_ff  <= req_ch.start_of_file;
      end
   end

   tgad_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (s1_byte_ff),
      .start_of_file (s1_sof_ff),
      .has_result    (has_result),
      .result        (result)
   );

   tgad_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .has_result (has_result),
      .result     (result),
      .advance    (advance),
      .rsp_ch     (rsp_ch)
   );

   `TGAD_ASSERT_NEXT(a_held_byte_kept, clock, reset, s1_valid_ff && !advance, s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_sof_ff))
   `TGAD_ASSERT_SAME(a_pixel_channels, clock, reset, rsp_ch.valid && (rsp_ch.kind == KIND_PIXEL), (rsp_ch.channel_count == CHAN_RGB) || (rsp_ch.channel_count == CHAN_RGBA))
   `TGAD_ASSERT_SAME(a_pixel_repeat, clock, reset, rsp_ch.valid && (rsp_ch.kind == KIND_PIXEL), rsp_ch.repeat_res != 8'd0)
   `TGAD_ASSERT_SAME(a_error_empty, clock, reset, rsp_ch.valid && (rsp_ch.kind == KIND_ERROR), (rsp_ch.channel_count == 3'd0) && (rsp_ch.repeat_res == 8'd0) && !rsp_ch.last)

endmodule
